// File: rtl/core/itoa_pkg.sv
// Shared types, constants and digit encoding for the radix integer-to-ASCII block.
package itoa_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int NUM_W          = 64;
    localparam int BASE_W         = 5;
    localparam int CHAR_W         = 8;
    localparam int DIGIT_W        = 4;
    localparam int Q_DEPTH        = 2;

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_F = 8'h66;

    // Input item as seen on the port
    typedef struct packed {
        logic signed [NUM_W-1:0] number;
        logic [BASE_W-1:0]       base;
        logic                    unsigned_mode;
        logic                    lowercase;
    } t_in_item;

    // Result item, one per character
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              negative;
        logic              last;
    } t_out_item;

    // Classified job handed from front to back
    typedef struct packed {
        logic [NUM_W-1:0]  mag;
        logic [BASE_W-1:0] radix;
        logic              negative;
        logic              lowercase;
    } t_job;

    // Digit value to ASCII, "0123456789abcdef" or "0123456789ABCDEF"
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic lower);
        logic [CHAR_W-1:0] code;
        if (d < DIGIT_W'(10)) begin
            code = ASCII_ZERO + CHAR_W'(d);
        end else if (lower) begin
            code = ASCII_LOWER_A + CHAR_W'(d - DIGIT_W'(10));
        end else begin
            code = ASCII_UPPER_A + CHAR_W'(d - DIGIT_W'(10));
        end
        return code;
    endfunction

endpackage

// File: rtl/core/itoa_front.sv
// Front end: input handshake, base clamping, sign and magnitude extraction.
module itoa_front #(
    parameter int DATA_WIDTH = itoa_pkg::DATA_WIDTH_DEF
) (
    input  logic              i_valid,
    output logic              o_stall,
    input  itoa_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_push,
    output itoa_pkg::t_job    o_job
);
    import itoa_pkg::*;

    logic [DATA_WIDTH-1:0] w_value;
    logic [DATA_WIDTH-1:0] w_mag;
    logic                  w_neg;
    logic [BASE_W-1:0]     w_radix;

    // Accept whenever the queue has room
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // Sign handling on the low DATA_WIDTH bits only
    assign w_value = i_item.number[DATA_WIDTH-1:0];
    assign w_neg   = !i_item.unsigned_mode && w_value[DATA_WIDTH-1];
    assign w_mag   = w_neg ? (~w_value + DATA_WIDTH'(1)) : w_value;

    // Clamp radix into 2..16
    always_comb begin
        if (i_item.base < BASE_MIN) begin
            w_radix = BASE_MIN;
        end else if (i_item.base > BASE_MAX) begin
            w_radix = BASE_MAX;
        end else begin
            w_radix = i_item.base;
        end
    end

    assign o_job.mag       = NUM_W'(w_mag);
    assign o_job.radix     = w_radix;
    assign o_job.negative  = w_neg;
    assign o_job.lowercase = i_item.lowercase;

endmodule

// File: rtl/core/itoa_fifo.sv
// Short job queue between front and back.
module itoa_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  itoa_pkg::t_job                    i_job,
    output logic                              o_full,
    input  logic                              i_pop,
    output itoa_pkg::t_job                    o_job,
    output logic                              o_empty,
    output logic [$clog2(itoa_pkg::Q_DEPTH+1)-1:0] o_level
);
    import itoa_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int LW = $clog2(Q_DEPTH + 1);

    t_job          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [LW-1:0] r_level;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_level == LW'(Q_DEPTH));
    assign o_empty = (r_level == '0);
    assign o_level = r_level;
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
            end
            if (w_push && !w_pop) begin
                r_level <= LW'(r_level + 1'b1);
            end else if (w_pop && !w_push) begin
                r_level <= LW'(r_level - 1'b1);
            end
        end
    end

endmodule

// File: rtl/core/itoa_back.sv
// Back end: serial radix division into a digit buffer, then MSB-first emission.
module itoa_back #(
    parameter int DATA_WIDTH = itoa_pkg::DATA_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itoa_pkg::t_job      i_job,
    input  logic                i_avail,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output itoa_pkg::t_out_item o_item
);
    import itoa_pkg::*;

    localparam int CHUNKS = (DATA_WIDTH + 7) / 8;
    localparam int VW     = CHUNKS * 8;
    localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int AW     = $clog2(DATA_WIDTH);
    localparam int NW     = $clog2(DATA_WIDTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [VW-1:0]     r_val;
    logic [DIGIT_W-1:0] r_rem;
    logic [BASE_W-1:0] r_radix;
    logic              r_neg;
    logic              r_lower;
    logic [CW-1:0]     r_chunk;
    logic [NW-1:0]     r_cnt;
    logic [NW-1:0]     r_left;
    logic              r_rd_vld;
    logic              r_rd_last;
    logic [CHAR_W-1:0] r_rd_data;
    logic              r_out_vld;
    t_out_item         r_out;
    logic [CHAR_W-1:0] r_mem [DATA_WIDTH];

    logic [7:0]         w_top;
    logic [7:0]         w_qbyte;
    logic [DIGIT_W-1:0] w_rem;
    logic [VW-1:0]      n_val;
    logic               w_last_chunk;
    logic               w_mem_we;
    logic               w_out_free;
    logic               w_out_load;
    logic               w_rd_issue;
    logic [AW-1:0]      w_rd_addr;

    // One byte of restoring division per cycle, remainder stays below radix
    always_comb begin
        logic [DIGIT_W-1:0] rem;
        logic [BASE_W-1:0]  trial;
        rem     = r_rem;
        w_qbyte = '0;
        w_top   = r_val[VW-1 -: 8];
        for (int i = 7; i >= 0; i--) begin
            trial = {rem, w_top[i]};
            if (trial >= r_radix) begin
                w_qbyte[i] = 1'b1;
                rem        = DIGIT_W'(trial - r_radix);
            end else begin
                rem        = trial[DIGIT_W-1:0];
            end
        end
        w_rem = rem;
    end

    // Quotient bytes shift in as dividend bytes shift out
    assign n_val        = (r_val << 8) | VW'(w_qbyte);
    assign w_last_chunk = (r_chunk == CW'(CHUNKS - 1));
    assign w_mem_we     = (r_state == S_DIV) && w_last_chunk;

    // Emission: registered memory read feeding the output register
    assign w_out_free = !r_out_vld || !i_stall;
    assign w_out_load = r_rd_vld && w_out_free;
    assign w_rd_issue = (r_state == S_EMIT) && (r_left != '0) && (!r_rd_vld || w_out_free);
    assign w_rd_addr  = AW'(r_left - 1'b1);

    assign o_pop   = (r_state == S_IDLE) && i_avail;
    assign o_valid = r_out_vld;
    assign o_item  = r_out;

    // Digit buffer, least significant digit at address zero
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_cnt[AW-1:0]] <= digit_char(w_rem, r_lower);
        end
        if (w_rd_issue) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Sequencer, division datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_chunk   <= '0;
            r_cnt     <= '0;
            r_left    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_val   <= VW'(i_job.mag[DATA_WIDTH-1:0]);
                        r_radix <= i_job.radix;
                        r_neg   <= i_job.negative;
                        r_lower <= i_job.lowercase;
                        r_rem   <= '0;
                        r_chunk <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_val <= n_val;
                    if (w_last_chunk) begin
                        r_rem   <= '0;
                        r_chunk <= '0;
                        r_cnt   <= NW'(r_cnt + 1'b1);
                        if (n_val == '0) begin
                            r_left  <= NW'(r_cnt + 1'b1);
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_rem   <= w_rem;
                        r_chunk <= CW'(r_chunk + 1'b1);
                    end
                end
                S_EMIT: begin
                    if (w_rd_issue) begin
                        r_left    <= NW'(r_left - 1'b1);
                        r_rd_last <= (r_left == NW'(1));
                    end
                    if ((r_left == '0) && !r_rd_vld) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Read data stage
            if (w_rd_issue) begin
                r_rd_vld <= 1'b1;
            end else if (w_out_load) begin
                r_rd_vld <= 1'b0;
            end

            // Output register
            if (w_out_load) begin
                r_out_vld       <= 1'b1;
                r_out.character <= r_rd_data;
                r_out.negative  <= r_neg;
                r_out.last      <= r_rd_last;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/core/radix_integer_to_ascii_top.sv
// Top level of the radix integer-to-ASCII converter.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): one item holds a value,
// a radix (clamped into 2..16) and the unsigned and lowercase flags. Items go
// into a two-entry job queue, so up to two items are taken while a conversion
// is still running.
// Output channel (o_out_valid / i_out_stall / o_out_item): one item per digit,
// most significant first, with the sign flag on every digit and last on the
// final one.
// Timing: the divider handles one byte of the value per cycle and forms one
// digit per pass over all ceil(DATA_WIDTH/8) bytes of the value.
// Characters leave at one per cycle while the receiver does not stall; a
// stall holds the output item and pauses the digit buffer reads.
// Reset (synchronous, active low) empties the queue and drops any conversion
// in progress; no output item is valid after reset.
module radix_integer_to_ascii_top #(
    parameter int DATA_WIDTH = itoa_pkg::DATA_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  itoa_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output itoa_pkg::t_out_item o_out_item
);
    import itoa_pkg::*;

    localparam int LVL_W = $clog2(Q_DEPTH + 1);

    logic             w_push;
    logic             w_full;
    logic             w_empty;
    logic             w_pop;
    t_job             w_front_job;
    t_job             w_back_job;
    logic [LVL_W-1:0] w_level;

    itoa_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_front_job)
    );

    itoa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_back_job),
        .o_empty (w_empty),
        .o_level (w_level)
    );

    itoa_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_back_job),
        .i_avail (!w_empty),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

    // Every emitted character is a digit of radix 16 or below
    a_digit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_item.character >= ASCII_ZERO && o_out_item.character <= ASCII_NINE) ||
             (o_out_item.character >= ASCII_UPPER_A &&
              o_out_item.character <= ASCII_UPPER_F) ||
             (o_out_item.character >= ASCII_LOWER_A &&
              o_out_item.character <= ASCII_LOWER_F)))
        else $error("output character is not a digit code");

    // Queue level never passes its depth, and a full queue stalls the input
    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_level <= LVL_W'(Q_DEPTH)) && (w_full == o_in_stall))
        else $error("job queue level out of range");

    // The sign flag does not change inside one conversion
    a_sign_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_item.last) |=>
            (!o_out_valid || (o_out_item.negative == $past(o_out_item.negative))))
        else $error("negative flag changed within a conversion");

endmodule

// File: tb/radix_integer_to_ascii_top_tb.sv
// Testbench for radix_integer_to_ascii_top: directed and random conversions checked per digit.
`timescale 1ns / 1ps

module radix_integer_to_ascii_top_tb;

    import itoa_pkg::*;

    localparam int DATA_W = DATA_WIDTH_DEF;

    // Holds the expected digit stream and checks what the block sends
    class digit_scoreboard;
        t_out_item   expected_digits[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // Work out the digits of one accepted number, most significant first
        function void note_number(t_in_item it);
            logic [NUM_W-1:0]  width_mask;
            logic [NUM_W-1:0]  mag;
            logic [BASE_W-1:0] radix;
            logic              neg;
            logic [CHAR_W-1:0] chars[$];
            string             alphabet;
            t_out_item         d;
            width_mask = {NUM_W{1'b1}} >> (NUM_W - DATA_W);
            mag        = it.number & width_mask;
            radix      = it.base;
            if (radix < BASE_MIN) begin
                radix = BASE_MIN;
            end
            if (radix > BASE_MAX) begin
                radix = BASE_MAX;
            end
            alphabet = it.lowercase ? "0123456789abcdef" : "0123456789ABCDEF";
            neg = !it.unsigned_mode && mag[DATA_W-1];
            if (neg) begin
                mag = (~mag + 1'b1) & width_mask;
            end
            do begin
                chars.push_front(alphabet[int'(mag % radix)]);
                mag = mag / radix;
            end while (mag != 0);
            foreach (chars[i]) begin
                d.character = chars[i];
                d.negative  = neg;
                d.last      = (i == chars.size() - 1);
                expected_digits.push_back(d);
            end
        endfunction

        // Compare one received digit with the oldest expectation
        function void check_digit(t_out_item got);
            t_out_item want;
            if (expected_digits.size() == 0) begin
                $display("%0t: unexpected digit, got char %h neg %b last %b",
                         $time, got.character, got.negative, got.last);
                errors++;
                return;
            end
            want = expected_digits.pop_front();
            if (got.character !== want.character) begin
                $display("%0t: character mismatch, expected %h actual %h",
                         $time, want.character, got.character);
                errors++;
            end
            if (got.negative !== want.negative) begin
                $display("%0t: negative mismatch, expected %b actual %b",
                         $time, want.negative, got.negative);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch, expected %b actual %b",
                         $time, want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction
    endclass

    logic      i_clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;

    digit_scoreboard sb = new();

    radix_integer_to_ascii_top #(
        .DATA_WIDTH (DATA_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #1_500_000;
        $display("radix_integer_to_ascii_top test failed");
        $finish;
    end

    // Receiver: check accepted digits, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_digit(out_item);
        end
        out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    function automatic t_in_item mk_item(logic [NUM_W-1:0] num, logic [BASE_W-1:0] base,
                                         logic uns, logic low);
        t_in_item it;
        it.number        = num;
        it.base          = base;
        it.unsigned_mode = uns;
        it.lowercase     = low;
        return it;
    endfunction

    // Present one item, with random idle cycles ahead of it, until it is taken
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall) begin
            @(posedge i_clk);
        end
        sb.note_number(it);
    endtask

    // Hold the sender off until every digit has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_in_item random_item();
        logic [NUM_W-1:0]  num;
        logic [BASE_W-1:0] base;
        logic [NUM_W-1:0]  wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: num = wide;
            1: num = NUM_W'($urandom_range(0, 1000));
            2: num = -NUM_W'($urandom_range(0, 1000));
            3: num = $urandom_range(0, 1) ? {1'b1, {(NUM_W-1){1'b0}}} + $urandom_range(0, 3)
                                          : {1'b0, {(NUM_W-1){1'b1}}} - $urandom_range(0, 3);
            4: num = wide >> $urandom_range(0, NUM_W - 1);
            default: num = -(wide >> $urandom_range(0, NUM_W - 1));
        endcase
        if ($urandom_range(0, 9) == 0) begin
            base = BASE_W'($urandom_range(0, 31));
        end else begin
            base = BASE_W'($urandom_range(2, 16));
        end
        return mk_item(num, base, 1'($urandom), 1'($urandom));
    endfunction

    initial begin
        t_in_item directed[$];

        // Zero, sign extremes, clamped bases and letter case
        directed.push_back(mk_item(64'd0, 5'd10, 1'b0, 1'b0));
        directed.push_back(mk_item(64'd0, 5'd2, 1'b1, 1'b1));
        directed.push_back(mk_item(64'd1, 5'd16, 1'b0, 1'b0));
        directed.push_back(mk_item({64{1'b1}}, 5'd10, 1'b0, 1'b0));
        directed.push_back(mk_item({64{1'b1}}, 5'd16, 1'b1, 1'b1));
        directed.push_back(mk_item({64{1'b1}}, 5'd16, 1'b1, 1'b0));
        directed.push_back(mk_item({64{1'b1}}, 5'd2, 1'b1, 1'b0));
        directed.push_back(mk_item(64'h8000_0000_0000_0000, 5'd2, 1'b0, 1'b0));
        directed.push_back(mk_item(64'h8000_0000_0000_0000, 5'd16, 1'b0, 1'b1));
        directed.push_back(mk_item(64'h8000_0000_0000_0000, 5'd10, 1'b1, 1'b0));
        directed.push_back(mk_item(64'h7fff_ffff_ffff_ffff, 5'd2, 1'b0, 1'b1));
        directed.push_back(mk_item(64'h7fff_ffff_ffff_ffff, 5'd10, 1'b0, 1'b0));
        directed.push_back(mk_item(64'h0123_4567_89ab_cdef, 5'd16, 1'b0, 1'b1));
        directed.push_back(mk_item(64'hfedc_ba98_7654_3210, 5'd16, 1'b1, 1'b0));
        directed.push_back(mk_item(64'd255, 5'd0, 1'b0, 1'b0));
        directed.push_back(mk_item(64'd255, 5'd1, 1'b1, 1'b1));
        directed.push_back(mk_item(64'd1000, 5'd17, 1'b0, 1'b1));
        directed.push_back(mk_item(64'hdead_beef, 5'd31, 1'b1, 1'b0));
        directed.push_back(mk_item(-64'sd12345, 5'd7, 1'b0, 1'b0));
        directed.push_back(mk_item(-64'sd12345, 5'd7, 1'b1, 1'b1));
        directed.push_back(mk_item(64'd35, 5'd15, 1'b0, 1'b1));
        directed.push_back(mk_item(64'd3, 5'd3, 1'b0, 1'b0));
        directed.push_back(mk_item(64'd9, 5'd9, 1'b1, 1'b0));

        // Hold reset, then release it
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling
        foreach (directed[i]) begin
            send_item(directed[i]);
        end
        wait_drained();

        // Random part in three idling phases
        tx_idle_pct = 16;
        rx_idle_pct = 56;
        repeat (50) send_item(random_item());
        wait_drained();

        tx_idle_pct = 56;
        rx_idle_pct = 16;
        repeat (50) send_item(random_item());
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (50) send_item(random_item());
        wait_drained();

        // Let any stray digit show up before the verdict
        repeat (700) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("radix_integer_to_ascii_top test passed");
        end else begin
            $display("radix_integer_to_ascii_top test failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/itoa_pkg.sv
rtl/core/itoa_front.sv
rtl/core/itoa_fifo.sv
rtl/core/itoa_back.sv
rtl/core/radix_integer_to_ascii_top.sv
tb/radix_integer_to_ascii_top_tb.sv
